@@ sv/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// shared widths, reciprocal constants and calendar helpers for the
// epoch seconds to calendar converter
// ----------------------------------------------------------------------------
package esc_pkg;

  // pipeline depth, input accept to result valid
  localparam int unsigned NUM_STAGES = 6;

  typedef logic [31:0] epoch_t;
  typedef logic [15:0] days_t;     // whole days since 1970, at most 49710
  typedef logic [16:0] sod_t;      // seconds within the day
  typedef logic [10:0] mod_t;      // minutes within the day
  typedef logic [7:0]  yoff_t;     // years since 1970
  typedef logic [8:0]  yday_t;

  // 86400 = 675 << 7, the odd part is divided by reciprocal
  localparam int unsigned DAY_POW2_W   = 7;
  localparam logic [9:0]  DAY_ODD      = 10'd675;
  localparam logic [25:0] RECIP_DAY    = 26'd50903317;   // ceil(2^35 / 675)
  localparam int unsigned SHIFT_DAY    = 35;

  localparam logic [23:0] RECIP_60     = 24'd8947849;    // ceil(2^29 / 60)
  localparam int unsigned SHIFT_60     = 29;
  localparam logic [16:0] RECIP_7      = 17'd74899;      // ceil(2^19 / 7)
  localparam int unsigned SHIFT_7      = 19;
  localparam logic [23:0] RECIP_365    = 24'd11767034;   // ceil(2^32 / 365)
  localparam int unsigned SHIFT_365    = 32;

  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [2:0]  DAYS_PER_WK  = 3'd7;
  localparam logic [2:0]  EPOCH_WDAY   = 3'd4;           // 1970-01-01 was a thursday
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
  localparam yoff_t       YOFF_1900    = 8'd70;
  localparam yoff_t       YOFF_2100    = 8'd130;         // only non-leap century year in range

  // gregorian rule over 1970..2106
  function automatic logic is_leap(input yoff_t yo);
    yoff_t s;
    s = yo + 8'd2;
    return (s[1:0] == 2'b00) && (yo != YOFF_2100);
  endfunction

  // zero-based day of year on which a month starts
  function automatic yday_t month_start(input logic [3:0] m, input logic leap);
    yday_t base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) base = base + 9'd1;
    return base;
  endfunction

endpackage

@@ sv/esc_ifs.sv @@
// ----------------------------------------------------------------------------
// esc channel interfaces
// valid/ready channels for timestamps in and calendar items out
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [7:0] year_since_1900;
  logic [8:0] day_of_year;
  logic [3:0] month;
  logic [4:0] day_of_month;

  modport source (
    output valid, output second, output minute, output hour, output weekday,
    output year_since_1900, output day_of_year, output month, output day_of_month,
    input ready
  );
  modport sink (
    input valid, input second, input minute, input hour, input weekday,
    input year_since_1900, input day_of_year, input month, input day_of_month,
    output ready
  );
endinterface

@@ sv/epoch_seconds_to_calendar_unit.sv @@
// depth: six register stages from the accepting edge to out valid
// throughput: one item per cycle unless the output stalls (multiply pipeline)
// a stalled output freezes every stage, so nothing is lost or repeated
// reset: synchronous active-low rst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// unsigned unix seconds to utc broken-down time, fully pipelined
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit import esc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  esc_in_if.sink    in_ch,
  esc_out_if.source out_ch
);

  // one valid bit per stage, moving in lockstep with the data registers
  logic [NUM_STAGES-1:0] v_r;
  logic                  adv;

  days_t days;
  sod_t  sod;

  // the whole pipe advances unless the output item is waiting to be taken
  assign adv         = !v_r[NUM_STAGES-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NUM_STAGES-2:0], in_ch.valid};
    end
  end

  // stages 1-2: days and seconds of the day via reciprocal of 675
  esc_day_split u_split (
    .clk     (clk),
    .en      (adv),
    .epoch_i (in_ch.epoch_seconds),
    .days_o  (days),
    .sod_o   (sod)
  );

  // stages 3-6: time of day and weekday
  esc_clock u_clock (
    .clk       (clk),
    .en        (adv),
    .days_i    (days),
    .sod_i     (sod),
    .second_o  (out_ch.second),
    .minute_o  (out_ch.minute),
    .hour_o    (out_ch.hour),
    .weekday_o (out_ch.weekday)
  );

  // stages 3-6: year estimate and correction, then month lookup
  esc_date u_date (
    .clk               (clk),
    .en                (adv),
    .days_i            (days),
    .year_since_1900_o (out_ch.year_since_1900),
    .day_of_year_o     (out_ch.day_of_year),
    .month_o           (out_ch.month),
    .day_of_month_o    (out_ch.day_of_month)
  );

  assign out_ch.valid = v_r[NUM_STAGES-1];

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(v_r))
    else $error("stage valids moved during an output stall");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.second < 6'd60 && out_ch.minute < 6'd60 &&
                      out_ch.hour < 5'd24 && out_ch.weekday < 3'd7))
    else $error("time of day or weekday out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month < 4'd12 && out_ch.day_of_month != 5'd0 &&
                      out_ch.day_of_year <= 9'd365 &&
                      out_ch.year_since_1900 >= 8'd70 &&
                      out_ch.year_since_1900 <= 8'd206))
    else $error("calendar date out of range");
`endif

endmodule

@@ sv/esc_day_split.sv @@
// ----------------------------------------------------------------------------
// esc_day_split
// two stages: splits a timestamp into whole days and seconds of the day
// ----------------------------------------------------------------------------
module esc_day_split import esc_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  epoch_t epoch_i,
  output days_t  days_o,
  output sod_t   sod_o
);

  logic [50:0] prod_r, prod_nxt;
  epoch_t      t_r;
  days_t       days_r, days_nxt;
  sod_t        sod_r, sod_nxt;
  logic [25:0] day_base;
  logic [25:0] rem_full;

  // stage 1: (t >> 7) * recip(675)
  assign prod_nxt = 51'(epoch_i[31:DAY_POW2_W]) * 51'(RECIP_DAY);

  // stage 2: quotient and remainder
  always_comb begin
    days_nxt = prod_r[SHIFT_DAY +: 16];
    day_base = 26'(days_nxt) * 26'(DAY_ODD);
    rem_full = 26'(t_r[31:DAY_POW2_W]) - day_base;
    sod_nxt  = {rem_full[9:0], t_r[DAY_POW2_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      t_r    <= epoch_i;
      days_r <= days_nxt;
      sod_r  <= sod_nxt;
    end
  end

  assign days_o = days_r;
  assign sod_o  = sod_r;

endmodule

@@ sv/esc_clock.sv @@
// ----------------------------------------------------------------------------
// esc_clock
// four stages: second, minute, hour and weekday
// ----------------------------------------------------------------------------
module esc_clock import esc_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  days_t      days_i,
  input  sod_t       sod_i,
  output logic [5:0] second_o,
  output logic [5:0] minute_o,
  output logic [4:0] hour_o,
  output logic [2:0] weekday_o
);

  // stage 3
  logic [40:0] pmin_r;
  logic [31:0] pwd_r;
  sod_t        sod3_r;
  days_t       wx3_r;
  days_t       wx;
  // stage 4
  mod_t        mod4_r, mod4_nxt;
  logic [5:0]  sec4_r, sec4_nxt;
  logic [2:0]  wd4_r, wd4_nxt;
  logic [12:0] wq;
  // stage 5
  logic [34:0] phr_r;
  mod_t        mod5_r;
  logic [5:0]  sec5_r;
  logic [2:0]  wd5_r;
  // stage 6
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec6_r;
  logic [2:0]  wd6_r;

  assign wx = days_i + 16'(EPOCH_WDAY);

  always_comb begin
    mod4_nxt = pmin_r[SHIFT_60 +: 11];
    sec4_nxt = 6'(sod3_r - 17'(mod4_nxt) * 17'(SECS_PER_MIN));
    wq       = pwd_r[SHIFT_7 +: 13];
    wd4_nxt  = 3'(wx3_r - 16'(wq) * 16'(DAYS_PER_WK));
    hour_nxt = phr_r[SHIFT_60 +: 5];
    min_nxt  = 6'(mod5_r - 11'(hour_nxt) * 11'(SECS_PER_MIN));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmin_r <= 41'(sod_i) * 41'(RECIP_60);
      pwd_r  <= 32'(wx) * 32'(RECIP_7);
      sod3_r <= sod_i;
      wx3_r  <= wx;
      mod4_r <= mod4_nxt;
      sec4_r <= sec4_nxt;
      wd4_r  <= wd4_nxt;
      phr_r  <= 35'(mod4_r) * 35'(RECIP_60);
      mod5_r <= mod4_r;
      sec5_r <= sec4_r;
      wd5_r  <= wd4_r;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec6_r <= sec5_r;
      wd6_r  <= wd5_r;
    end
  end

  assign second_o  = sec6_r;
  assign minute_o  = min_r;
  assign hour_o    = hour_r;
  assign weekday_o = wd6_r;

endmodule

@@ sv/esc_date.sv @@
// ----------------------------------------------------------------------------
// esc_date
// four stages: year, day of year, month and day of month
// ----------------------------------------------------------------------------
module esc_date import esc_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  days_t      days_i,
  output logic [7:0] year_since_1900_o,
  output logic [8:0] day_of_year_o,
  output logic [3:0] month_o,
  output logic [4:0] day_of_month_o
);

  // stage 3
  logic [39:0] pyr_r;
  days_t       days3_r;
  // stage 4
  yoff_t       yest4_r, yest4_nxt;
  logic [16:0] ys4_r, ys4_nxt;
  days_t       days4_r;
  logic [8:0]  yest_inc;
  // stage 5
  yoff_t       yo5_r, yo5_nxt;
  yday_t       yday5_r, yday5_nxt;
  logic        leap5_r, leap5_nxt;
  logic [16:0] ybase;
  // stage 6
  yoff_t       year6_r;
  yday_t       yday6_r;
  logic [3:0]  mon6_r, mon6_nxt;
  logic [4:0]  dom6_r, dom6_nxt;
  yday_t       mstart;

  always_comb begin
    // year estimate from days / 365 is never low and at most one high
    yest4_nxt = pyr_r[SHIFT_365 +: 8];
    yest_inc  = 9'(yest4_nxt) + 9'd1;
    ys4_nxt   = 17'(yest4_nxt) * 17'(DAYS_PER_YR) + 17'(yest_inc[8:2])
              - ((yest4_nxt > YOFF_2100) ? 17'd1 : 17'd0);

    if (ys4_r > 17'(days4_r)) begin
      yo5_nxt = yest4_r - 8'd1;
      ybase   = ys4_r - 17'(DAYS_PER_YR) - (is_leap(yo5_nxt) ? 17'd1 : 17'd0);
    end else begin
      yo5_nxt = yest4_r;
      ybase   = ys4_r;
    end
    yday5_nxt = 9'(17'(days4_r) - ybase);
    leap5_nxt = is_leap(yo5_nxt);

    // month search, compares are independent
    mon6_nxt = 4'd0;
    mstart   = month_start(4'd0, leap5_r);
    for (int m = 1; m < 12; m++) begin
      if (yday5_r >= month_start(4'(m), leap5_r)) begin
        mon6_nxt = 4'(m);
        mstart   = month_start(4'(m), leap5_r);
      end
    end
    dom6_nxt = 5'(yday5_r - mstart + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pyr_r   <= 40'(days_i) * 40'(RECIP_365);
      days3_r <= days_i;
      yest4_r <= yest4_nxt;
      ys4_r   <= ys4_nxt;
      days4_r <= days3_r;
      yo5_r   <= yo5_nxt;
      yday5_r <= yday5_nxt;
      leap5_r <= leap5_nxt;
      year6_r <= yo5_r + YOFF_1900;
      yday6_r <= yday5_r;
      mon6_r  <= mon6_nxt;
      dom6_r  <= dom6_nxt;
    end
  end

  assign year_since_1900_o = year6_r;
  assign day_of_year_o     = yday6_r;
  assign month_o           = mon6_r;
  assign day_of_month_o    = dom6_r;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the epoch seconds to calendar converter: a table
// of calendar corner cases, then about 1100 random timestamps aimed at day,
// month and year edges, with random idling on both channels. every result item
// is compared field by field with the typed-in or computed date of its stamp
// ----------------------------------------------------------------------------
module tb_top;
  import esc_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MINUTE = 60;
  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned YEAR_BASE = 1900;
  localparam int unsigned EPOCH_WEEKDAY = 4;     // 1970-01-01 fell on a thursday
  localparam int unsigned DIR_ROWS = 22;
  localparam int unsigned RAND_ITEMS = 1100;
  localparam int unsigned CALM_ITEMS = 150;      // tail of the run with no idling
  localparam int unsigned PHASE_LEN = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // broken-down time as the result channel carries it
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } utc_date_t;

  // what is still owed by the block, with the stamp kept for reporting
  typedef struct packed {
    logic [31:0] stamp;
    utc_date_t   date;
  } owed_date_t;

  typedef struct {
    logic [31:0] stamp;
    bit          pinned;   // date typed in below rather than worked out
    utc_date_t   date;
  } stamp_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  esc_in_if  in_ch();
  esc_out_if out_ch();

  epoch_seconds_to_calendar_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar corner cases; only the epoch itself, the end of its first day, the
  // start of the next day and the last representable second carry a typed-in
  // date, the rest go through the software conversion
  // ---------------------------------------------------------------------------
  stamp_row_t corner_stamps [DIR_ROWS] = '{
    // thursday 1970-01-01 00:00:00
    '{32'd0, 1'b1, '{6'd0, 6'd0, 5'd0, 3'd4, 8'd70, 9'd0, 4'd0, 5'd1}},
    '{32'd1, 1'b0, '0},
    '{32'd59, 1'b0, '0},
    '{32'd60, 1'b0, '0},
    '{32'd3599, 1'b0, '0},
    '{32'd3600, 1'b0, '0},
    // last second of the first day
    '{32'd86399, 1'b1, '{6'd59, 6'd59, 5'd23, 3'd4, 8'd70, 9'd0, 4'd0, 5'd1}},
    // friday 1970-01-02 00:00:00
    '{32'd86400, 1'b1, '{6'd0, 6'd0, 5'd0, 3'd5, 8'd70, 9'd1, 4'd0, 5'd2}},
    '{32'd28857600, 1'b0, '0},     // 1970-12-01, start of the last month
    '{32'd68169600, 1'b0, '0},     // 1972-02-29, first leap day
    '{32'd94608000, 1'b0, '0},     // 1972-12-31, day 365 of a leap year
    '{32'd951782400, 1'b0, '0},    // 2000-02-29, century leap year
    '{32'd978220799, 1'b0, '0},    // 2000-12-30 23:59:59
    '{32'd2147483647, 1'b0, '0},   // top of the signed range
    '{32'd2147483648, 1'b0, '0},
    '{32'd4102444799, 1'b0, '0},   // 2099-12-31 23:59:59
    '{32'd4107456000, 1'b0, '0},   // 2100-02-28, century year that is not leap
    '{32'd4107542400, 1'b0, '0},   // 2100-03-01 straight after 28 february
    '{32'd4291747200, 1'b0, '0},   // 2106-01-01, last year in range
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    // 2106-02-07 06:28:15, a sunday, largest stamp
    '{32'hFFFF_FFFF, 1'b1, '{6'd15, 6'd28, 5'd6, 3'd0, 8'd206, 9'd37, 4'd1, 5'd7}}
  };

  owed_date_t  owed_dates [$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;     // chance of a sender gap after each item
  int unsigned stall_pct = 0;   // chance per cycle of a receiver stall burst
  int unsigned stall_left = 0;
  logic        sink_ready = 1'b0;

  // side data riding along with the item on the input channel
  logic        item_pinned = 1'b0;
  utc_date_t   item_date = '0;

  assign out_ch.ready = sink_ready;

  // ---------------------------------------------------------------------------
  // software conversion: split the stamp into day and second of day, walk
  // the days through whole gregorian years, then through the months
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned year_length(input int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  function automatic utc_date_t utc_date_of(input logic [31:0] stamp);
    int unsigned sod;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen [12];
    utc_date_t   d;
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    sod = stamp % SECS_PER_DAY;
    days = stamp / SECS_PER_DAY;
    d.second = 6'(sod % SECS_PER_MINUTE);
    d.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MINUTE);
    d.hour = 5'(sod / SECS_PER_HOUR);
    d.weekday = 3'((days + EPOCH_WEEKDAY) % 7);
    yr = EPOCH_YEAR;
    while (days >= year_length(yr)) begin
      days -= year_length(yr);
      yr++;
    end
    d.day_of_year = 9'(days);
    if (leap_year(yr)) mlen[1] = 29;
    mon = 0;
    // december takes whatever is left
    while (mon < 11 && days >= mlen[mon]) begin
      days -= mlen[mon];
      mon++;
    end
    d.year_since_1900 = 8'(yr - YEAR_BASE);
    d.month = 4'(mon);
    d.day_of_month = 5'(days + 1);
    return d;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] stamp,
                                      input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: stamp %0d %s expected %0d got %0d", $time, stamp, name, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: record each accepted timestamp and check each result item
  // against the oldest date still owed, both at the same clock edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    owed_date_t owed;
    utc_date_t  got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        owed.stamp = in_ch.epoch_seconds;
        owed.date = item_pinned ? item_date : utc_date_of(in_ch.epoch_seconds);
        owed_dates.push_back(owed);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.second, out_ch.minute, out_ch.hour, out_ch.weekday,
                out_ch.year_since_1900, out_ch.day_of_year, out_ch.month,
                out_ch.day_of_month};
        if (owed_dates.size() == 0) begin
          $display("%0t: result item with nothing owed, expected none got %h", $time, got);
          err_count++;
        end else begin
          owed = owed_dates.pop_front();
          check_field("second", owed.stamp, owed.date.second, got.second);
          check_field("minute", owed.stamp, owed.date.minute, got.minute);
          check_field("hour", owed.stamp, owed.date.hour, got.hour);
          check_field("weekday", owed.stamp, owed.date.weekday, got.weekday);
          check_field("year_since_1900", owed.stamp, owed.date.year_since_1900,
                      got.year_since_1900);
          check_field("day_of_year", owed.stamp, owed.date.day_of_year, got.day_of_year);
          check_field("month", owed.stamp, owed.date.month, got.month);
          check_field("day_of_month", owed.stamp, owed.date.day_of_month, got.day_of_month);
        end
      end
    end
  end

  // receiver: ready drops in random bursts, at a rate set per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(13);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // offer one timestamp and hold it until taken, then maybe leave a gap;
  // valid stays high straight into the next item when there is no gap
  task automatic send_stamp(input logic [31:0] stamp, input bit pinned, input utc_date_t date);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.epoch_seconds <= stamp;
    item_pinned <= pinned;
    item_date <= date;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // the first wait lets the scoreboard log the last accepted item
  task automatic wait_for_owed_dates;
    @(posedge clk);
    while (owed_dates.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] stamp;
    longint      near;
    int unsigned yr;
    int unsigned ydays;
    int unsigned day_pick;
    in_ch.valid = 1'b0;
    in_ch.epoch_seconds = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases, under moderate idling on both sides
    gap_pct = 30;
    stall_pct = 30;
    foreach (corner_stamps[i])
      send_stamp(corner_stamps[i].stamp, corner_stamps[i].pinned, corner_stamps[i].date);

    // sender holds off until the pipeline has emptied
    in_ch.valid <= 1'b0;
    wait_for_owed_dates();

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      // idling profile changes per phase; the tail runs flat out
      if (i >= RAND_ITEMS - CALM_ITEMS) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (i % PHASE_LEN == 0) begin
        case ($urandom_range(3))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 15; stall_pct = 15; end
          2: begin gap_pct = 50; stall_pct = 10; end
          default: begin gap_pct = 10; stall_pct = 50; end
        endcase
      end

      case ($urandom_range(3))
        0: stamp = $urandom;
        1: begin
          // either side of midnight on a random day
          near = longint'($urandom_range(49709)) * SECS_PER_DAY;
          case ($urandom_range(3))
            0: stamp = 32'(near);
            1: stamp = 32'(near + 1);
            2: stamp = 32'(near + SECS_PER_DAY - 1);
            default: stamp = 32'(near + $urandom_range(SECS_PER_DAY - 1));
          endcase
        end
        2: begin
          // around new year, the end of february, mid-year or the end of the year
          yr = $urandom_range(EPOCH_YEAR, 2106);
          ydays = 0;
          for (int unsigned y = EPOCH_YEAR; y < yr; y++) ydays += year_length(y);
          case ($urandom_range(6))
            0: day_pick = 0;
            1: day_pick = 58;
            2: day_pick = 59;
            3: day_pick = 60;
            4: day_pick = 181;
            5: day_pick = 364;
            default: day_pick = 365;
          endcase
          near = longint'(ydays + day_pick) * SECS_PER_DAY
                 + longint'($urandom_range(2)) - 1;
          if (near < 0 || near > longint'(32'hFFFF_FFFF)) stamp = $urandom;
          else stamp = 32'(near);
        end
        default: begin
          // both ends of the range
          if ($urandom_range(1) == 0) stamp = $urandom_range(200000);
          else stamp = 32'hFFFF_FFFF - $urandom_range(200000);
        end
      endcase
      send_stamp(stamp, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    wait_for_owed_dates();
    // let anything stray fall out of the pipeline
    repeat (2 * NUM_STAGES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ epoch_seconds_to_calendar_unit.f @@
sv/esc_pkg.sv
sv/esc_ifs.sv
sv/esc_day_split.sv
sv/esc_clock.sv
sv/esc_date.sv
sv/epoch_seconds_to_calendar_unit.sv
tb/sv/tb_top.sv
